[sv/ml1dc_pkg.sv]
// ----------------------------------------------------------------------------
// ml1dc_pkg
// Types, constants and fixed-point helpers of the level-1 MOSFET DC stamp.
// ----------------------------------------------------------------------------
package ml1dc_pkg;

	localparam int unsigned MAX_NODES = 1024;
	localparam logic [9:0] NODE_LIM = (MAX_NODES >= 1024) ? 10'd1023 : 10'(MAX_NODES - 1);

	// configuration port
	localparam int unsigned CFG_IW = 3;
	localparam int unsigned CFG_DW = 47;
	localparam logic [CFG_IW-1:0] REG_VTO   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_GAMMA = 3'd1;
	localparam logic [CFG_IW-1:0] REG_PHI   = 3'd2;
	localparam logic [CFG_IW-1:0] REG_KP    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_LAMBDA = 3'd4;

	localparam logic [31:0] VTO_RST    = 32'd16777216;
	localparam logic [30:0] GAMMA_RST  = 31'd0;
	localparam logic [30:0] PHI_RST    = 31'd10066330;
	localparam logic [46:0] KP_RST     = 47'd21990232;
	localparam logic [30:0] LAMBDA_RST = 31'd0;

	// pipeline layout
	localparam int unsigned NST        = 28;
	localparam int unsigned SQ_FIRST   = 1;
	localparam int unsigned SQ_LAST    = 10;
	localparam int unsigned SQ_PER     = 3;
	localparam int unsigned DV_FIRST   = 12;
	localparam int unsigned DV_LAST    = 22;
	localparam int unsigned DV_PER     = 4;

	// entry positions inside one device burst
	localparam logic [3:0] E_DD = 4'd0;
	localparam logic [3:0] E_DS = 4'd1;
	localparam logic [3:0] E_DG = 4'd2;
	localparam logic [3:0] E_DB = 4'd3;
	localparam logic [3:0] E_SD = 4'd4;
	localparam logic [3:0] E_SS = 4'd5;
	localparam logic [3:0] E_SG = 4'd6;
	localparam logic [3:0] E_SB = 4'd7;
	localparam logic [3:0] E_RHS_D = 4'd8;
	localparam logic [3:0] E_RHS_S = 4'd9;

	localparam logic KIND_MATRIX = 1'b0;
	localparam logic KIND_RHS    = 1'b1;

	localparam logic signed [63:0] ONE_Q24  = 64'sd16777216;
	localparam logic signed [63:0] ILIM     = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] NEG_ILIM = -64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] OUT_MAX  = 64'sd140737488355327;
	localparam logic signed [63:0] OUT_MIN  = -64'sd140737488355328;
	localparam logic [29:0] SQRT_ONE = 30'd4096;

	typedef struct packed {
		logic        neg;
		logic [63:0] p00;
		logic [62:0] p01;
		logic [62:0] p10;
		logic [61:0] p11;
	} pp_t;

	typedef struct packed {
		logic [59:0] x;
		logic [33:0] r;
		logic [29:0] q;
	} sqst_t;

	typedef struct packed {
		logic [43:0] n;
		logic [30:0] r;
		logic [30:0] d;
		logic [43:0] q;
	} dvst_t;

	typedef struct packed {
		logic [9:0]        nd;
		logic [9:0]        ng;
		logic [9:0]        ns;
		logic [9:0]        nb;
		logic signed [63:0] vgs;
		logic signed [63:0] vds;
		logic signed [63:0] vbs;
		logic              rad_pos;
		sqst_t             sqa;
		sqst_t             sqb;
		dvst_t             dv;
		pp_t               pa;
		pp_t               pb;
		pp_t               pc;
		logic signed [63:0] clm;
		logic signed [63:0] kvds;
		logic signed [63:0] vv;
		logic signed [63:0] gm_lin;
		logic signed [63:0] diff;
		logic signed [63:0] body;
		logic signed [63:0] vgst;
		logic signed [63:0] dmv;
		logic              lin;
		logic              on;
		logic signed [63:0] p;
		logic signed [63:0] q;
		logic signed [63:0] kvg;
		logic signed [63:0] kdmv;
		logic signed [63:0] kx;
		logic signed [63:0] gm_sat;
		logic signed [63:0] gdl1;
		logic signed [63:0] gm;
		logic signed [63:0] ids;
		logic signed [63:0] kxl;
		logic signed [63:0] gds;
		logic signed [63:0] t1;
		logic signed [63:0] t2;
		logic signed [63:0] ieq;
		logic signed [63:0] gmbs;
		logic [9:0][47:0]  val;
	} pipe_t;

	function automatic logic signed [63:0] clampi(input logic signed [63:0] v);
		if (v > ILIM) return ILIM;
		if (v < NEG_ILIM) return NEG_ILIM;
		return v;
	endfunction

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		return clampi(s);
	endfunction

	// partial products of two magnitudes, split into a 32-bit low and a 31-bit high part
	function automatic pp_t mul_pp(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [63:0] ua;
		logic [63:0] ub;
		pp_t r;
		ua = a[63] ? (~a + 64'd1) : a;
		ub = b[63] ? (~b + 64'd1) : b;
		r.neg = a[63] ^ b[63];
		r.p00 = ua[31:0] * ub[31:0];
		r.p01 = ua[31:0] * ub[62:32];
		r.p10 = ua[62:32] * ub[31:0];
		r.p11 = ua[62:32] * ub[62:32];
		return r;
	endfunction

	// sum partial products, shift, truncate toward zero and saturate
	function automatic logic signed [63:0] mul_fin(input pp_t p, input int unsigned sh);
		logic [127:0] full;
		logic [127:0] shr;
		logic [63:0] mag;
		full = {64'd0, p.p00} + ({65'd0, p.p01} << 32) + ({65'd0, p.p10} << 32)
			+ ({66'd0, p.p11} << 64);
		shr = full >> sh;
		if (shr > {64'd0, ILIM}) mag = ILIM;
		else mag = shr[63:0];
		return $signed(p.neg ? (~mag + 64'd1) : mag);
	endfunction

	function automatic sqst_t sqrt_step(input sqst_t s);
		logic [33:0] rr;
		logic [33:0] t;
		sqst_t o;
		rr = {s.r[31:0], s.x[59:58]};
		t = {2'b00, s.q, 2'b01};
		o.x = {s.x[57:0], 2'b00};
		if (rr >= t) begin
			o.r = rr - t;
			o.q = {s.q[28:0], 1'b1};
		end else begin
			o.r = rr;
			o.q = {s.q[28:0], 1'b0};
		end
		return o;
	endfunction

	function automatic dvst_t div_step(input dvst_t s);
		logic [31:0] rr;
		logic [31:0] dx;
		dvst_t o;
		rr = {s.r, s.n[43]};
		dx = {1'b0, s.d};
		o.n = {s.n[42:0], 1'b0};
		o.d = s.d;
		if (rr >= dx) begin
			o.r = 31'(rr - dx);
			o.q = {s.q[42:0], 1'b1};
		end else begin
			o.r = rr[30:0];
			o.q = {s.q[42:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [47:0] sat48(input logic signed [63:0] v);
		if (v > OUT_MAX) return OUT_MAX[47:0];
		if (v < OUT_MIN) return OUT_MIN[47:0];
		return v[47:0];
	endfunction

	function automatic logic [9:0] node_of(input logic [9:0] n);
		return (n > NODE_LIM) ? NODE_LIM : n;
	endfunction

endpackage

[sv/ml1dc_in_if.sv]
// ----------------------------------------------------------------------------
// ml1dc_in_if
// Device channel: terminal voltages and node indices of one MOSFET.
// ----------------------------------------------------------------------------
interface ml1dc_in_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] drain_voltage;
	logic signed [31:0] gate_voltage;
	logic signed [31:0] source_voltage;
	logic signed [31:0] bulk_voltage;
	logic [9:0]        drain_node;
	logic [9:0]        gate_node;
	logic [9:0]        source_node;
	logic [9:0]        bulk_node;

	modport source (output valid, output drain_voltage, output gate_voltage,
		output source_voltage, output bulk_voltage, output drain_node, output gate_node,
		output source_node, output bulk_node, input ready);
	modport sink (input valid, input drain_voltage, input gate_voltage,
		input source_voltage, input bulk_voltage, input drain_node, input gate_node,
		input source_node, input bulk_node, output ready);
endinterface

[sv/ml1dc_out_if.sv]
// ----------------------------------------------------------------------------
// ml1dc_out_if
// Stamp channel: one matrix or right-hand-side entry per transfer.
// ----------------------------------------------------------------------------
interface ml1dc_out_if;
	logic              valid;
	logic              ready;
	logic              entry_kind;
	logic [9:0]        row_index;
	logic [9:0]        col_index;
	logic signed [47:0] stamp_value;
	logic              last_entry;

	modport source (output valid, output entry_kind, output row_index, output col_index,
		output stamp_value, output last_entry, input ready);
	modport sink (input valid, input entry_kind, input row_index, input col_index,
		input stamp_value, input last_entry, output ready);
endinterface

[sv/mosfet_level1_dc_stamp_core.sv]
// ----------------------------------------------------------------------------
// mosfet_level1_dc_stamp_core
// Level-1 MOSFET DC linearization: one device in, ten stamp entries out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one device (four Q8.24 terminal voltages, four node
//   indices) per transfer. out_ch carries ten entries per device: eight
//   matrix entries, then the drain and source right-hand-side entries; the
//   tenth has last_entry set. The user writes model parameters on the wr_*
//   port only while the block is idle; the block does not enforce this.
//   Path: a transfer loads stage 0; the device passes 27 more pipeline
//   stages, then the output register, where its first entry is valid;
//   the other nine follow one per cycle while out_ch.ready stays high.
//   Bottleneck: the single output channel carries ten entries per device
//   and so bounds the device rate. The 28-stage pipeline (two square
//   roots three bits a stage, a divider four bits a stage, 32x32 partial
//   product multipliers) takes a new device in every cycle it advances.
//   Reset: registers load their default parameters, pipeline and output
//   register empty.
//   Stall: when the output register holds an unfinished device and the last
//   stage is full, the whole pipeline holds and in_ch.ready drops; nothing
//   is lost or repeated.
// ----------------------------------------------------------------------------
module mosfet_level1_dc_stamp_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [ml1dc_pkg::CFG_IW-1:0] wr_index,
	input  logic [ml1dc_pkg::CFG_DW-1:0] wr_data,
	ml1dc_in_if.sink                  in_ch,
	ml1dc_out_if.source               out_ch
);
	import ml1dc_pkg::*;

	logic [31:0] vto_q;
	logic [30:0] gam_q;
	logic [30:0] phi_q;
	logic [46:0] kp_q;
	logic [30:0] lam_q;

	logic signed [63:0] vto_w;
	logic signed [63:0] gam_w;
	logic signed [63:0] kp_w;
	logic signed [63:0] lam_w;

	pipe_t pipe_s [NST];
	logic  valid_s [NST];
	pipe_t nxt [NST];

	pipe_t      ser_q;
	logic       ser_v_q;
	logic [3:0] cnt_q;
	logic       out_xfer;
	logic       load;
	logic       en;

	assign vto_w = {{32{vto_q[31]}}, vto_q};
	assign gam_w = {33'd0, gam_q};
	assign kp_w  = {17'd0, kp_q};
	assign lam_w = {33'd0, lam_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vto_q <= VTO_RST;
			gam_q <= GAMMA_RST;
			phi_q <= PHI_RST;
			kp_q  <= KP_RST;
			lam_q <= LAMBDA_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_VTO:    vto_q <= wr_data[31:0];
				REG_GAMMA:  gam_q <= wr_data[30:0];
				REG_PHI:    phi_q <= wr_data[30:0];
				REG_KP:     kp_q  <= wr_data[46:0];
				REG_LAMBDA: lam_q <= wr_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic signed [63:0] rad;
		logic [29:0] sq;
		nxt[0] = '0;
		nxt[0].vgs = 64'(in_ch.gate_voltage) - 64'(in_ch.source_voltage);
		nxt[0].vds = 64'(in_ch.drain_voltage) - 64'(in_ch.source_voltage);
		nxt[0].vbs = 64'(in_ch.bulk_voltage) - 64'(in_ch.source_voltage);
		rad = $signed({33'd0, phi_q}) - nxt[0].vbs;
		nxt[0].rad_pos = rad > 64'sd0;
		nxt[0].sqa.x = nxt[0].rad_pos ? {rad[35:0], 24'd0} : 60'd0;
		nxt[0].sqb.x = {5'd0, phi_q, 24'd0};
		nxt[0].nd = node_of(in_ch.drain_node);
		nxt[0].ng = node_of(in_ch.gate_node);
		nxt[0].ns = node_of(in_ch.source_node);
		nxt[0].nb = node_of(in_ch.bulk_node);

		for (int k = 1; k < NST; k++) nxt[k] = pipe_s[k-1];

		// square roots of the body-effect radicand and of phi
		for (int k = SQ_FIRST; k <= SQ_LAST; k++) begin
			for (int j = 0; j < SQ_PER; j++) begin
				nxt[k].sqa = sqrt_step(nxt[k].sqa);
				nxt[k].sqb = sqrt_step(nxt[k].sqb);
			end
		end
		// gamma / (2 sqrt(phi - vbs)) for gmbs
		for (int k = DV_FIRST; k <= DV_LAST; k++) begin
			for (int j = 0; j < DV_PER; j++) nxt[k].dv = div_step(nxt[k].dv);
		end

		nxt[1].pa = mul_pp(lam_w, pipe_s[0].vds);
		nxt[1].pb = mul_pp(kp_w, pipe_s[0].vds);
		nxt[1].pc = mul_pp(pipe_s[0].vds, pipe_s[0].vds);

		nxt[2].clm  = sadd(ONE_Q24, mul_fin(pipe_s[1].pa, 24));
		nxt[2].kvds = mul_fin(pipe_s[1].pb, 24);
		nxt[2].vv   = mul_fin(pipe_s[1].pc, 25);

		nxt[3].pa = mul_pp(pipe_s[2].kvds, pipe_s[2].clm);
		nxt[4].gm_lin = mul_fin(pipe_s[3].pa, 24);

		sq = pipe_s[10].rad_pos ? pipe_s[10].sqa.q : SQRT_ONE;
		nxt[11].diff = $signed({34'd0, pipe_s[10].sqa.q}) - $signed({34'd0, pipe_s[10].sqb.q});
		nxt[11].dv.n = {gam_q[19:0], 24'd0};
		nxt[11].dv.r = {20'd0, gam_q[30:20]};
		nxt[11].dv.d = {sq, 1'b0};
		nxt[11].dv.q = '0;

		nxt[12].pa = mul_pp(gam_w, pipe_s[11].diff);
		nxt[13].body = mul_fin(pipe_s[12].pa, 24);
		nxt[14].vgst = sadd(pipe_s[13].vgs, -sadd(vto_w, pipe_s[13].body));

		nxt[15].pa = mul_pp(pipe_s[14].vgst, pipe_s[14].vds);
		nxt[15].pb = mul_pp(pipe_s[14].vgst, pipe_s[14].vgst);
		nxt[15].pc = mul_pp(kp_w, pipe_s[14].vgst);
		nxt[15].dmv = sadd(pipe_s[14].vgst, -pipe_s[14].vds);
		nxt[15].lin = pipe_s[14].vds <= pipe_s[14].vgst;
		nxt[15].on  = pipe_s[14].vgst > 64'sd0;

		nxt[16].p   = sadd(mul_fin(pipe_s[15].pa, 24), -pipe_s[15].vv);
		nxt[16].q   = mul_fin(pipe_s[15].pb, 25);
		nxt[16].kvg = mul_fin(pipe_s[15].pc, 24);
		nxt[16].pa  = mul_pp(kp_w, pipe_s[15].dmv);

		nxt[17].kdmv = mul_fin(pipe_s[16].pa, 24);
		nxt[17].pa = mul_pp(kp_w, pipe_s[16].lin ? pipe_s[16].p : pipe_s[16].q);
		nxt[17].pb = mul_pp(pipe_s[16].kvg, pipe_s[16].clm);

		nxt[18].kx     = mul_fin(pipe_s[17].pa, 24);
		nxt[18].gm_sat = mul_fin(pipe_s[17].pb, 24);
		nxt[18].pa     = mul_pp(pipe_s[17].kdmv, pipe_s[17].clm);

		nxt[19].gdl1 = mul_fin(pipe_s[18].pa, 24);
		nxt[19].pa = mul_pp(pipe_s[18].kx, pipe_s[18].clm);
		nxt[19].pb = mul_pp(pipe_s[18].kx, lam_w);
		nxt[19].gm = !pipe_s[18].on ? 64'sd0 :
			(pipe_s[18].lin ? pipe_s[18].gm_lin : pipe_s[18].gm_sat);

		nxt[20].ids = pipe_s[19].on ? mul_fin(pipe_s[19].pa, 24) : 64'sd0;
		nxt[20].kxl = mul_fin(pipe_s[19].pb, 24);
		nxt[20].gds = !pipe_s[19].on ? 64'sd0 :
			(pipe_s[19].lin ? sadd(pipe_s[19].gdl1, nxt[20].kxl) : nxt[20].kxl);

		nxt[21].pa = mul_pp(pipe_s[20].gm, pipe_s[20].vgs);
		nxt[21].pb = mul_pp(pipe_s[20].gds, pipe_s[20].vds);

		nxt[22].t1 = mul_fin(pipe_s[21].pa, 24);
		nxt[22].t2 = mul_fin(pipe_s[21].pb, 24);

		nxt[23].ieq = sadd(sadd(pipe_s[22].ids, -pipe_s[22].t1), -pipe_s[22].t2);
		nxt[23].pa  = mul_pp($signed({20'd0, pipe_s[22].dv.q}), pipe_s[22].gm);

		nxt[24].gmbs = pipe_s[23].on ? mul_fin(pipe_s[23].pa, 24) : 64'sd0;
		nxt[25].pa = mul_pp(pipe_s[24].gmbs, pipe_s[24].vbs);
		nxt[26].ieq = sadd(pipe_s[25].ieq, -mul_fin(pipe_s[25].pa, 24));

		nxt[27].val[E_DD] = sat48(pipe_s[26].gds);
		nxt[27].val[E_DS] = sat48(sadd(sadd(-pipe_s[26].gds, -pipe_s[26].gm), -pipe_s[26].gmbs));
		nxt[27].val[E_DG] = sat48(pipe_s[26].gm);
		nxt[27].val[E_DB] = sat48(pipe_s[26].gmbs);
		nxt[27].val[E_SD] = sat48(-pipe_s[26].gds);
		nxt[27].val[E_SS] = sat48(sadd(sadd(pipe_s[26].gds, pipe_s[26].gm), pipe_s[26].gmbs));
		nxt[27].val[E_SG] = sat48(-pipe_s[26].gm);
		nxt[27].val[E_SB] = sat48(-pipe_s[26].gmbs);
		nxt[27].val[E_RHS_D] = sat48(-pipe_s[26].ieq);
		nxt[27].val[E_RHS_S] = sat48(pipe_s[26].ieq);
	end

	assign out_xfer = out_ch.valid && out_ch.ready;
	assign load = !ser_v_q || (out_xfer && cnt_q == E_RHS_S);
	assign en = !valid_s[NST-1] || load;
	assign in_ch.ready = en;

	// advance the whole pipeline together; hold while the last stage waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) valid_s[k] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_ch.valid;
			for (int k = 1; k < NST; k++) valid_s[k] <= valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) pipe_s[k] <= nxt[k];
		end
		if (load) ser_q <= pipe_s[NST-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			cnt_q   <= E_DD;
		end else if (load) begin
			ser_v_q <= valid_s[NST-1];
			cnt_q   <= E_DD;
		end else if (out_xfer) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	assign out_ch.valid = ser_v_q;
	assign out_ch.last_entry = cnt_q == E_RHS_S;

	always_comb begin
		out_ch.entry_kind = KIND_MATRIX;
		out_ch.row_index = ser_q.nd;
		out_ch.col_index = ser_q.nd;
		out_ch.stamp_value = ser_q.val[E_DD];
		unique case (cnt_q)
			E_DD: ;
			E_DS: begin
				out_ch.col_index = ser_q.ns;
				out_ch.stamp_value = ser_q.val[E_DS];
			end
			E_DG: begin
				out_ch.col_index = ser_q.ng;
				out_ch.stamp_value = ser_q.val[E_DG];
			end
			E_DB: begin
				out_ch.col_index = ser_q.nb;
				out_ch.stamp_value = ser_q.val[E_DB];
			end
			E_SD: begin
				out_ch.row_index = ser_q.ns;
				out_ch.stamp_value = ser_q.val[E_SD];
			end
			E_SS: begin
				out_ch.row_index = ser_q.ns;
				out_ch.col_index = ser_q.ns;
				out_ch.stamp_value = ser_q.val[E_SS];
			end
			E_SG: begin
				out_ch.row_index = ser_q.ns;
				out_ch.col_index = ser_q.ng;
				out_ch.stamp_value = ser_q.val[E_SG];
			end
			E_SB: begin
				out_ch.row_index = ser_q.ns;
				out_ch.col_index = ser_q.nb;
				out_ch.stamp_value = ser_q.val[E_SB];
			end
			E_RHS_D: begin
				out_ch.entry_kind = KIND_RHS;
				out_ch.col_index = '0;
				out_ch.stamp_value = ser_q.val[E_RHS_D];
			end
			E_RHS_S: begin
				out_ch.entry_kind = KIND_RHS;
				out_ch.row_index = ser_q.ns;
				out_ch.col_index = '0;
				out_ch.stamp_value = ser_q.val[E_RHS_S];
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !out_ch.last_entry |=> out_ch.valid)
		else $error("stamp burst broken before its last entry");
	a_rhs_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.entry_kind == KIND_RHS |-> out_ch.col_index == '0)
		else $error("right-hand-side entry with nonzero column");
	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s[NST-1] |-> in_ch.ready)
		else $error("input stalled with an empty last stage");
	a_load_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		ser_v_q && !(out_xfer && out_ch.last_entry) |=> $stable(ser_q.val))
		else $error("output register changed inside a burst");
`endif

endmodule

[test/ml1dc_stamp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ml1dc_stamp_checker
// Watches the device and stamp channels and the parameter write port,
// predicts the ten stamp entries of every device and compares them in order.
// ----------------------------------------------------------------------------
module ml1dc_stamp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ml1dc_pkg::CFG_IW-1:0]  wr_index,
	input  logic [ml1dc_pkg::CFG_DW-1:0]  wr_data,
	ml1dc_in_if.sink                      dev_mon,
	ml1dc_out_if.sink                     stamp_mon,
	output int                            errors,
	output int                            pending
);
	import ml1dc_pkg::*;

	typedef struct packed {
		logic              kind;
		logic [9:0]        row;
		logic [9:0]        col;
		logic signed [47:0] value;
		logic              last;
	} stamp_t;

	localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	stamp_t            stamp_q[$];
	logic signed [63:0] p_vto;
	logic [30:0]       p_gamma;
	logic [30:0]       p_phi;
	logic [46:0]       p_kp;
	logic [30:0]       p_lambda;

	assign pending = stamp_q.size();

	function automatic logic signed [63:0] lim(input logic signed [63:0] v);
		if (v > LIM) return LIM;
		if (v < -LIM) return -LIM;
		return v;
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
		input logic signed [63:0] b);
		return lim(lim(a) + lim(b));
	endfunction

	// (a*b) >> sh, truncated toward zero, saturated
	function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
		input logic signed [63:0] b, input int sh);
		logic [127:0] prod;
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic signed [63:0] r;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		prod = ({64'd0, ua} * {64'd0, ub}) >> sh;
		r = (prod > {64'd0, LIM}) ? LIM : $signed(prod[63:0]);
		return (a[63] ^ b[63]) ? -r : r;
	endfunction

	function automatic logic signed [63:0] root_q24(input logic signed [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] bt;
		if (v <= 0) return 0;
		x = v << 24;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x -= r + bt;
				r = (r >> 1) + bt;
			end else r >>= 1;
			bt >>= 2;
		end
		return $signed(r);
	endfunction

	function automatic logic [47:0] clip48(input logic signed [63:0] v);
		if (v > 64'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
		if (v < -64'sd140737488355328) return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	function automatic logic [9:0] node_clip(input logic [9:0] n);
		return (n > NODE_LIM) ? NODE_LIM : n;
	endfunction

	task automatic predict_stamps(input logic signed [31:0] vd_i, vg_i, vs_i, vb_i,
		input logic [9:0] nd_i, ng_i, ns_i, nb_i);
		logic signed [63:0] vgs, vds, vbs, rad, body, vth, vgst, clm, p, kpp, kq;
		logic signed [63:0] ids, gm, gds, gmbs, ieq, sq, gam, phi, kp, lam;
		logic signed [63:0] v[10];
		logic [63:0] ratio;
		logic [9:0] nd, ng, ns, nb;
		stamp_t e;
		nd = node_clip(nd_i);
		ng = node_clip(ng_i);
		ns = node_clip(ns_i);
		nb = node_clip(nb_i);
		gam = {33'd0, p_gamma};
		phi = {33'd0, p_phi};
		kp = {17'd0, p_kp};
		lam = {33'd0, p_lambda};
		vgs = 64'(vg_i) - 64'(vs_i);
		vds = 64'(vd_i) - 64'(vs_i);
		vbs = 64'(vb_i) - 64'(vs_i);
		rad = phi - vbs;
		body = fmul(gam, root_q24(rad > 0 ? rad : 0) - root_q24(phi), 24);
		vth = add_sat(p_vto, body);
		vgst = add_sat(vgs, -vth);
		ids = 0; gm = 0; gds = 0; gmbs = 0;
		if (vgst > 0) begin
			clm = add_sat(ONE_Q24, fmul(lam, vds, 24));
			if (vds <= vgst) begin
				p = add_sat(fmul(vgst, vds, 24), -fmul(vds, vds, 25));
				kpp = fmul(kp, p, 24);
				ids = fmul(kpp, clm, 24);
				gm = fmul(fmul(kp, vds, 24), clm, 24);
				gds = add_sat(fmul(fmul(kp, add_sat(vgst, -vds), 24), clm, 24),
					fmul(kpp, lam, 24));
			end else begin
				kq = fmul(kp, fmul(vgst, vgst, 25), 24);
				ids = fmul(kq, clm, 24);
				gm = fmul(fmul(kp, vgst, 24), clm, 24);
				gds = fmul(kq, lam, 24);
			end
			// floor the radicand at one LSB so the divide is always defined
			sq = root_q24(rad > 0 ? rad : 1);
			ratio = ({33'd0, p_gamma} << 24) / (2 * sq);
			gmbs = fmul($signed(ratio), gm, 24);
		end
		ieq = add_sat(ids, -fmul(gm, vgs, 24));
		ieq = add_sat(ieq, -fmul(gds, vds, 24));
		ieq = add_sat(ieq, -fmul(gmbs, vbs, 24));
		v[0] = gds;
		v[1] = add_sat(add_sat(-gds, -gm), -gmbs);
		v[2] = gm;
		v[3] = gmbs;
		v[4] = -gds;
		v[5] = add_sat(add_sat(gds, gm), gmbs);
		v[6] = -gm;
		v[7] = -gmbs;
		v[8] = -ieq;
		v[9] = ieq;
		for (int k = 0; k < 10; k++) begin
			e.kind = (k >= 8) ? KIND_RHS : KIND_MATRIX;
			e.row = (k < 4 || k == 8) ? nd : ns;
			case (k % 4)
				0: e.col = nd;
				1: e.col = ns;
				2: e.col = ng;
				default: e.col = nb;
			endcase
			if (k >= 8) e.col = 10'd0;
			e.value = clip48(v[k]);
			e.last = (k == 9);
			stamp_q.push_back(e);
		end
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stamp_t w;
		if (!arst_n) begin
			errors <= 0;
			p_vto <= 64'(signed'(VTO_RST));
			p_gamma <= GAMMA_RST;
			p_phi <= PHI_RST;
			p_kp <= KP_RST;
			p_lambda <= LAMBDA_RST;
			stamp_q.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_VTO:    p_vto <= 64'(signed'(wr_data[31:0]));
					REG_GAMMA:  p_gamma <= wr_data[30:0];
					REG_PHI:    p_phi <= wr_data[30:0];
					REG_KP:     p_kp <= wr_data[46:0];
					REG_LAMBDA: p_lambda <= wr_data[30:0];
					default: ;
				endcase
			end
			if (dev_mon.valid && dev_mon.ready)
				predict_stamps(dev_mon.drain_voltage, dev_mon.gate_voltage,
					dev_mon.source_voltage, dev_mon.bulk_voltage, dev_mon.drain_node,
					dev_mon.gate_node, dev_mon.source_node, dev_mon.bulk_node);
			if (stamp_mon.valid && stamp_mon.ready) begin
				if (stamp_q.size() == 0) report("unexpected entry", 0, 0);
				else begin
					w = stamp_q.pop_front();
					if (stamp_mon.entry_kind !== w.kind)
						report("entry_kind", stamp_mon.entry_kind, w.kind);
					if (stamp_mon.row_index !== w.row)
						report("row_index", stamp_mon.row_index, w.row);
					if (stamp_mon.col_index !== w.col)
						report("col_index", stamp_mon.col_index, w.col);
					if (stamp_mon.stamp_value !== w.value)
						report("stamp_value", stamp_mon.stamp_value, w.value);
					if (stamp_mon.last_entry !== w.last)
						report("last_entry", stamp_mon.last_entry, w.last);
				end
			end
		end
	end
endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Level-1 MOSFET stamp bench: drives devices and parameter settings with
// random idling on both channels and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	import ml1dc_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN_CYCLES = 60;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic [CFG_IW-1:0]   wr_index;
	logic [CFG_DW-1:0]   wr_data;
	int                  errors;
	int                  pending;
	int                  idle_cycles;
	int                  src_idle_pct;
	int                  snk_idle_pct;

	ml1dc_in_if  dev_ch();
	ml1dc_out_if stamp_ch();

	mosfet_level1_dc_stamp_core i_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .in_ch(dev_ch.sink), .out_ch(stamp_ch.source)
	);

	ml1dc_stamp_checker i_checker (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .dev_mon(dev_ch.sink), .stamp_mon(stamp_ch.sink),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// receiver stalls
	always @(negedge clk)
		stamp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((dev_ch.valid && dev_ch.ready) || (stamp_ch.valid && stamp_ch.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG) begin
			$display("DONE: errors detected");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// drop valid after the last device, then let the block drain
	task automatic wait_empty();
		dev_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_device(input logic [31:0] vd, vg, vs, vb,
		input logic [9:0] nd, ng, ns, nb);
		while ($urandom_range(99) < src_idle_pct) begin
			dev_ch.valid <= 1'b0;
			@(negedge clk);
		end
		dev_ch.valid <= 1'b1;
		dev_ch.drain_voltage <= vd;
		dev_ch.gate_voltage <= vg;
		dev_ch.source_voltage <= vs;
		dev_ch.bulk_voltage <= vb;
		dev_ch.drain_node <= nd;
		dev_ch.gate_node <= ng;
		dev_ch.source_node <= ns;
		dev_ch.bulk_node <= nb;
		@(posedge clk);
		while (!dev_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly small terminal voltages so the device conducts in every region
	function automatic logic [31:0] rand_volt();
		case ($urandom_range(9))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(32'h0A00_0000)) - 32'sh0500_0000);
		endcase
	endfunction

	function automatic logic [9:0] rand_node();
		return $urandom_range(3) == 0 ? 10'($urandom()) : 10'($urandom_range(15));
	endfunction

	task automatic random_devices(input int n);
		for (int i = 0; i < n; i++)
			send_device(rand_volt(), rand_volt(), rand_volt(), rand_volt(),
				rand_node(), rand_node(), rand_node(), rand_node());
	endtask

	task automatic random_params(input int mode);
		write_reg(REG_VTO, mode == 0 ? 47'(32'h8000_0000) : mode == 1 ? 47'(32'h7FFF_FFFF)
			: 47'(32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000)));
		write_reg(REG_GAMMA, mode == 0 ? 47'h7FFF_FFFF : 47'($urandom_range(32'h0200_0000)));
		write_reg(REG_PHI, mode == 0 ? 47'd1 : mode == 1 ? 47'h7FFF_FFFF
			: 47'($urandom_range(32'h0200_0000, 32'h0080_0000)));
		write_reg(REG_KP, mode == 0 ? 47'h7FFF_FFFF_FFFF
			: {15'd0, $urandom_range(32'h0400_0000)});
		write_reg(REG_LAMBDA, mode == 0 ? 47'h7FFF_FFFF : 47'($urandom_range(32'h0040_0000)));
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		dev_ch.valid = 1'b0;
		dev_ch.drain_voltage = '0;
		dev_ch.gate_voltage = '0;
		dev_ch.source_voltage = '0;
		dev_ch.bulk_voltage = '0;
		dev_ch.drain_node = '0;
		dev_ch.gate_node = '0;
		dev_ch.source_node = '0;
		dev_ch.bulk_node = '0;
		stamp_ch.ready = 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		idle_cycles = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: default parameters, cutoff, linear, saturation, extremes
		send_device(32'h0, 32'h0, 32'h0, 32'h0, 10'd0, 10'd0, 10'd0, 10'd0);
		send_device(32'h0100_0000, 32'h0300_0000, 32'h0, 32'h0, 10'd1, 10'd2, 10'd3, 10'd4);
		send_device(32'h0500_0000, 32'h0300_0000, 32'h0, 32'h0, 10'd5, 10'd6, 10'd7, 10'd8);
		send_device(32'hFF00_0000, 32'h0300_0000, 32'h0, 32'h0, 10'd1023, 10'd1023,
			10'd1023, 10'd1023);
		send_device(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			10'd1023, 10'd0, 10'd512, 10'd341);
		send_device(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			10'd682, 10'd1, 10'd0, 10'd1023);
		send_device(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			10'h3FF, 10'h2AA, 10'h155, 10'h3FF);
		wait_empty();
		// body effect on: bulk above the surface potential, zero radicand, bulk below source
		write_reg(REG_GAMMA, 47'h0080_0000);
		write_reg(REG_LAMBDA, 47'h0020_0000);
		send_device(32'h0200_0000, 32'h0400_0000, 32'h0, 32'h0200_0000, 10'd1, 10'd2,
			10'd3, 10'd4);
		send_device(32'h0200_0000, 32'h0400_0000, 32'h0, 32'h0099_999A, 10'd1, 10'd2,
			10'd3, 10'd4);
		send_device(32'h0200_0000, 32'h0400_0000, 32'h0, 32'hFE00_0000, 10'd1, 10'd2,
			10'd3, 10'd4);
		wait_empty();
		// zero surface potential
		write_reg(REG_PHI, 47'd0);
		send_device(32'h0200_0000, 32'h0400_0000, 32'h0, 32'h0, 10'd9, 10'd8, 10'd7, 10'd6);
		send_device(32'h0200_0000, 32'h0400_0000, 32'h0, 32'hFF00_0000, 10'd9, 10'd8,
			10'd7, 10'd6);
		wait_empty();
		// extreme parameter sets with directed and random devices
		random_params(0);
		send_device(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 10'd1,
			10'd2, 10'd3, 10'd4);
		send_device(32'h0100_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 10'd1, 10'd2, 10'd3, 10'd4);
		random_devices(6);
		wait_empty();
		random_params(1);
		random_devices(6);
		wait_empty();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
				1: begin src_idle_pct = 45; snk_idle_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_idle_pct = 45; end
				default: begin src_idle_pct = 8; snk_idle_pct = 8; end
			endcase
			random_params(2);
			random_devices(27);
			wait_empty();
		end

		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

[files.f]
sv/ml1dc_pkg.sv
sv/ml1dc_in_if.sv
sv/ml1dc_out_if.sv
sv/mosfet_level1_dc_stamp_core.sv
test/ml1dc_stamp_checker.sv
test/tb.sv
